@@ rtl/packet_id_generator_unit_macros.svh @@
// Assertion macros for the packet id generator.
// Used by packet_id_generator_unit; expects clk and rst_n in scope.
`ifndef PACKET_ID_GENERATOR_UNIT_MACROS_SVH
`define PACKET_ID_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PIDG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidg assertion failed");
`define PIDG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidg assertion failed");
`else
`define PIDG_ASSERT_NOW(lbl, ante, cons)
`define PIDG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/pidg_pkg.sv @@
// Package for the packet id generator: payload types, constants,
// microcode control word, step map and the control store. No dependencies.
`default_nettype none

package pidg_pkg;

    localparam logic [31:0] MIX_K1        = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_K2        = 32'hC2B2_AE35;
    localparam logic [31:0] GOLDEN        = 32'h9E37_79B9;
    localparam logic [31:0] SEQ_LIMIT     = 32'hFFFF_FFFE;
    localparam logic [31:0] WAKE_SKIP     = 32'd256;
    localparam logic [31:0] LOW_BYTE_MASK = 32'h0000_00FF;

    localparam logic [2:0] KIND_HASH       = 3'd0;
    localparam logic [2:0] KIND_RAW        = 3'd1;
    localparam logic [2:0] KIND_ROTATE     = 3'd2;
    localparam logic [2:0] KIND_INIT       = 3'd3;
    localparam logic [2:0] KIND_QUERY      = 3'd4;
    localparam logic [2:0] KIND_INVALIDATE = 3'd5;

    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_SET   = 2'd1;
    localparam logic [1:0] MARK_CLEAR = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] entropy_a;
        logic [31:0] entropy_b;
        logic [31:0] entropy_c;
        logic [31:0] time_now;
        logic        stored_marker_ok;
        logic [31:0] kept_session;
        logic [31:0] kept_sequence;
        logic [31:0] stored_boots;
    } req_t;

    typedef struct packed {
        logic [63:0] packet_id;
        logic        persist_write;
        logic [31:0] persist_session;
        logic [31:0] persist_sequence;
        logic [31:0] persist_boots;
        logic [1:0]  marker_write;
        logic [31:0] cur_session;
        logic [31:0] cur_sequence;
        logic [31:0] cur_boots;
    } rsp_t;

    localparam int STEP_W = 5;
    localparam int OP_W   = 5;
    localparam int COND_W = 4;

    localparam logic [OP_W-1:0] OP_NOP        = OP_W'(0);
    localparam logic [OP_W-1:0] OP_KIND_MARK  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_HASH_MUL   = OP_W'(2);
    localparam logic [OP_W-1:0] OP_F1         = OP_W'(3);
    localparam logic [OP_W-1:0] OP_F2         = OP_W'(4);
    localparam logic [OP_W-1:0] OP_F3         = OP_W'(5);
    localparam logic [OP_W-1:0] OP_F3B        = OP_W'(6);
    localparam logic [OP_W-1:0] OP_F3_OR1     = OP_W'(7);
    localparam logic [OP_W-1:0] OP_ID_HASH    = OP_W'(8);
    localparam logic [OP_W-1:0] OP_ADVANCE    = OP_W'(9);
    localparam logic [OP_W-1:0] OP_SEQ_CLEAR  = OP_W'(10);
    localparam logic [OP_W-1:0] OP_ID_RAW     = OP_W'(11);
    localparam logic [OP_W-1:0] OP_RESTORE    = OP_W'(12);
    localparam logic [OP_W-1:0] OP_SKIP       = OP_W'(13);
    localparam logic [OP_W-1:0] OP_FRESH      = OP_W'(14);
    localparam logic [OP_W-1:0] OP_MUL_BOOTS  = OP_W'(15);
    localparam logic [OP_W-1:0] OP_MIX_PREV   = OP_W'(16);
    localparam logic [OP_W-1:0] OP_LOAD_C     = OP_W'(17);
    localparam logic [OP_W-1:0] OP_SES_FROM_X = OP_W'(18);
    localparam logic [OP_W-1:0] OP_EMIT       = OP_W'(19);

    localparam logic [COND_W-1:0] COND_NEXT        = COND_W'(0);
    localparam logic [COND_W-1:0] COND_ALWAYS      = COND_W'(1);
    localparam logic [COND_W-1:0] COND_DISPATCH    = COND_W'(2);
    localparam logic [COND_W-1:0] COND_IS_RAW      = COND_W'(3);
    localparam logic [COND_W-1:0] COND_BELOW_LIMIT = COND_W'(4);
    localparam logic [COND_W-1:0] COND_NO_MARKER   = COND_W'(5);
    localparam logic [COND_W-1:0] COND_SEQ_OPEN    = COND_W'(6);
    localparam logic [COND_W-1:0] COND_X_NONZERO   = COND_W'(7);
    localparam logic [COND_W-1:0] COND_CALL        = COND_W'(8);
    localparam logic [COND_W-1:0] COND_RETURN      = COND_W'(9);

    localparam logic [STEP_W-1:0] STEP_DISPATCH    = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_ID          = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_ID_F1       = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_ID_F2       = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_ID_HASH     = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_ADVANCE     = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_ROTATE      = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_ROT_RET     = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_RAW         = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_INIT        = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_INIT_SEQ    = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_INIT_GEN    = STEP_W'(11);
    localparam logic [STEP_W-1:0] STEP_RESTORE_RET = STEP_W'(12);
    localparam logic [STEP_W-1:0] STEP_SKIP        = STEP_W'(13);
    localparam logic [STEP_W-1:0] STEP_FRESH       = STEP_W'(14);
    localparam logic [STEP_W-1:0] STEP_FRESH_RET   = STEP_W'(15);
    localparam logic [STEP_W-1:0] STEP_GEN         = STEP_W'(16);
    localparam logic [STEP_W-1:0] STEP_GEN_MIX     = STEP_W'(17);
    localparam logic [STEP_W-1:0] STEP_GEN_A1      = STEP_W'(18);
    localparam logic [STEP_W-1:0] STEP_GEN_A2      = STEP_W'(19);
    localparam logic [STEP_W-1:0] STEP_GEN_A3      = STEP_W'(20);
    localparam logic [STEP_W-1:0] STEP_GEN_B1      = STEP_W'(21);
    localparam logic [STEP_W-1:0] STEP_GEN_B2      = STEP_W'(22);
    localparam logic [STEP_W-1:0] STEP_GEN_B3      = STEP_W'(23);
    localparam logic [STEP_W-1:0] STEP_GEN_TEST    = STEP_W'(24);
    localparam logic [STEP_W-1:0] STEP_GEN_C0      = STEP_W'(25);
    localparam logic [STEP_W-1:0] STEP_GEN_C1      = STEP_W'(26);
    localparam logic [STEP_W-1:0] STEP_GEN_C2      = STEP_W'(27);
    localparam logic [STEP_W-1:0] STEP_GEN_C3      = STEP_W'(28);
    localparam logic [STEP_W-1:0] STEP_GEN_END     = STEP_W'(29);
    localparam logic [STEP_W-1:0] STEP_DONE        = STEP_W'(30);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } uop_t;

    function automatic uop_t ucode_rom(input logic [STEP_W-1:0] step);
        uop_t w;
        case (step)
            STEP_DISPATCH:    w = '{OP_KIND_MARK, COND_DISPATCH, STEP_DONE};
            STEP_ID:          w = '{OP_HASH_MUL, COND_IS_RAW, STEP_RAW};
            STEP_ID_F1:       w = '{OP_F1, COND_NEXT, STEP_DONE};
            STEP_ID_F2:       w = '{OP_F2, COND_NEXT, STEP_DONE};
            STEP_ID_HASH:     w = '{OP_ID_HASH, COND_NEXT, STEP_DONE};
            STEP_ADVANCE:     w = '{OP_ADVANCE, COND_BELOW_LIMIT, STEP_DONE};
            STEP_ROTATE:      w = '{OP_NOP, COND_CALL, STEP_GEN};
            STEP_ROT_RET:     w = '{OP_SEQ_CLEAR, COND_ALWAYS, STEP_DONE};
            STEP_RAW:         w = '{OP_ID_RAW, COND_ALWAYS, STEP_ADVANCE};
            STEP_INIT:        w = '{OP_RESTORE, COND_NO_MARKER, STEP_FRESH};
            STEP_INIT_SEQ:    w = '{OP_NOP, COND_SEQ_OPEN, STEP_SKIP};
            STEP_INIT_GEN:    w = '{OP_NOP, COND_CALL, STEP_GEN};
            STEP_RESTORE_RET: w = '{OP_SEQ_CLEAR, COND_ALWAYS, STEP_DISPATCH};
            STEP_SKIP:        w = '{OP_SKIP, COND_ALWAYS, STEP_DISPATCH};
            STEP_FRESH:       w = '{OP_FRESH, COND_CALL, STEP_GEN};
            STEP_FRESH_RET:   w = '{OP_SEQ_CLEAR, COND_ALWAYS, STEP_DISPATCH};
            STEP_GEN:         w = '{OP_MUL_BOOTS, COND_NEXT, STEP_DONE};
            STEP_GEN_MIX:     w = '{OP_MIX_PREV, COND_NEXT, STEP_DONE};
            STEP_GEN_A1:      w = '{OP_F1, COND_NEXT, STEP_DONE};
            STEP_GEN_A2:      w = '{OP_F2, COND_NEXT, STEP_DONE};
            STEP_GEN_A3:      w = '{OP_F3B, COND_NEXT, STEP_DONE};
            STEP_GEN_B1:      w = '{OP_F1, COND_NEXT, STEP_DONE};
            STEP_GEN_B2:      w = '{OP_F2, COND_NEXT, STEP_DONE};
            STEP_GEN_B3:      w = '{OP_F3, COND_NEXT, STEP_DONE};
            STEP_GEN_TEST:    w = '{OP_NOP, COND_X_NONZERO, STEP_GEN_END};
            STEP_GEN_C0:      w = '{OP_LOAD_C, COND_NEXT, STEP_DONE};
            STEP_GEN_C1:      w = '{OP_F1, COND_NEXT, STEP_DONE};
            STEP_GEN_C2:      w = '{OP_F2, COND_NEXT, STEP_DONE};
            STEP_GEN_C3:      w = '{OP_F3_OR1, COND_NEXT, STEP_DONE};
            STEP_GEN_END:     w = '{OP_SES_FROM_X, COND_RETURN, STEP_DONE};
            STEP_DONE:        w = '{OP_EMIT, COND_ALWAYS, STEP_DONE};
            default:          w = '{OP_NOP, COND_ALWAYS, STEP_DONE};
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] dispatch_step(input logic [2:0] kind,
                                                        input logic       started);
        logic [STEP_W-1:0] s;
        if (!started && (kind == KIND_HASH || kind == KIND_RAW || kind == KIND_ROTATE ||
                         kind == KIND_INIT || kind == KIND_QUERY))
        begin
            s = STEP_INIT;
        end
        else
        begin
            case (kind)
                KIND_HASH:   s = STEP_ID;
                KIND_RAW:    s = STEP_ID;
                KIND_ROTATE: s = STEP_ROTATE;
                default:     s = STEP_DONE;
            endcase
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pidg_req_if.sv @@
// Request channel of the packet id generator: valid, ready, req_t payload.
// Depends on pidg_pkg.
`default_nettype none

interface pidg_req_if
    import pidg_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/pidg_rsp_if.sv @@
// Result channel of the packet id generator: valid, ready, rsp_t payload.
// Depends on pidg_pkg.
`default_nettype none

interface pidg_rsp_if
    import pidg_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/packet_id_generator_unit.sv @@
// Packet id generator: microcoded sequencer over one shared 32x32 multiplier.
// Depends on pidg_pkg, pidg_req_if, pidg_rsp_if and the assertion macros.
// Accept to result, one step a cycle, emit holding while an older result waits; a rotation
// adds the generator, more on the fallback word; worst is lazy exhausted restore+rotate.
// One item at a time: the next transaction can be taken in the same cycle that the result
// shows. Async active-low reset clears control state, counters and started, not the datapath.
`default_nettype none

`include "packet_id_generator_unit_macros.svh"

module packet_id_generator_unit
    import pidg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pidg_req_if.sink   req,
    pidg_rsp_if.source rsp
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] link_reg, link_next;
    logic              started_reg, started_next;
    logic [31:0]       ses_reg, ses_next;
    logic [31:0]       seq_reg, seq_next;
    logic [31:0]       boots_reg, boots_next;
    logic              out_valid_reg, out_valid_next;

    req_t              item_reg, item_next;
    logic [31:0]       x_reg, x_next;
    logic [31:0]       t_reg, t_next;
    logic [63:0]       id_reg, id_next;
    logic              pw_reg, pw_next;
    logic [31:0]       pws_reg, pws_next;
    logic [31:0]       pwq_reg, pwq_next;
    logic [31:0]       pwb_reg, pwb_next;
    logic [1:0]        mark_reg, mark_next;
    rsp_t              out_reg, out_next;

    uop_t              uop;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [31:0]       mul_lo;
    logic [31:0]       pre16;
    logic [31:0]       pre13;
    logic [32:0]       skip_sum;
    logic [31:0]       skip_seq;
    logic [STEP_W-1:0] step_inc;
    logic              take;
    logic              in_gen;
    logic              gen_link_ok;

    assign req.ready = !busy_reg;
    assign take      = req.valid && !busy_reg;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign uop      = ucode_rom(step_reg);
    assign pre16    = x_reg ^ (x_reg >> 16);
    assign pre13    = x_reg ^ (x_reg >> 13);
    assign skip_sum = {1'b0, item_reg.kept_sequence} + {1'b0, WAKE_SKIP};
    assign skip_seq = skip_sum[32] ? SEQ_LIMIT : skip_sum[31:0];
    assign step_inc = step_reg + STEP_W'(1);

    always_comb
    begin
        case (uop.op)
            OP_HASH_MUL:
            begin
                mul_a = seq_reg;
                mul_b = MIX_K1;
            end
            OP_F1:
            begin
                mul_a = pre16;
                mul_b = MIX_K1;
            end
            OP_F2:
            begin
                mul_a = pre13;
                mul_b = MIX_K2;
            end
            OP_MUL_BOOTS:
            begin
                mul_a = boots_reg;
                mul_b = GOLDEN;
            end
            OP_MIX_PREV:
            begin
                mul_a = ses_reg;
                mul_b = MIX_K1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_lo = mul_a * mul_b;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        link_next      = link_reg;
        started_next   = started_reg;
        ses_next       = ses_reg;
        seq_next       = seq_reg;
        boots_next     = boots_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        item_next      = item_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        id_next        = id_reg;
        pw_next        = pw_reg;
        pws_next       = pws_reg;
        pwq_next       = pwq_reg;
        pwb_next       = pwb_reg;
        mark_next      = mark_reg;
        out_next       = out_reg;

        if (take)
        begin
            busy_next = 1'b1;
            step_next = STEP_DISPATCH;
            item_next = req.payload;
            id_next   = '0;
            pw_next   = 1'b0;
            pws_next  = '0;
            pwq_next  = '0;
            pwb_next  = '0;
            mark_next = MARK_NONE;
        end
        else if (busy_reg)
        begin
            case (uop.op)
                OP_KIND_MARK:
                begin
                    if (item_reg.kind == KIND_INVALIDATE)
                    begin
                        mark_next = MARK_CLEAR;
                    end
                end
                OP_HASH_MUL:  x_next = ses_reg ^ mul_lo;
                OP_F1:        x_next = mul_lo;
                OP_F2:        x_next = mul_lo;
                OP_F3:        x_next = pre16;
                OP_F3B:       x_next = pre16 ^ item_reg.entropy_b;
                OP_F3_OR1:    x_next = pre16 | 32'd1;
                OP_ID_HASH:
                begin
                    id_next = {32'd0, pre16};
                    if ((seq_reg & LOW_BYTE_MASK) == 32'd0)
                    begin
                        pw_next  = 1'b1;
                        pws_next = ses_reg;
                        pwq_next = seq_reg;
                        pwb_next = boots_reg;
                    end
                end
                OP_ADVANCE:   seq_next = seq_reg + 32'd1;
                OP_SEQ_CLEAR:
                begin
                    seq_next = '0;
                    pw_next  = 1'b1;
                    pws_next = ses_reg;
                    pwq_next = '0;
                    pwb_next = boots_reg;
                end
                OP_ID_RAW:    id_next = {ses_reg, seq_reg};
                OP_RESTORE:
                begin
                    started_next = 1'b1;
                    ses_next     = item_reg.kept_session;
                    boots_next   = item_reg.stored_boots + 32'd1;
                end
                OP_SKIP:
                begin
                    seq_next = skip_seq;
                    pw_next  = 1'b1;
                    pws_next = ses_reg;
                    pwq_next = skip_seq;
                    pwb_next = boots_reg;
                end
                OP_FRESH:
                begin
                    started_next = 1'b1;
                    ses_next     = '0;
                    boots_next   = '0;
                    mark_next    = MARK_SET;
                end
                OP_MUL_BOOTS: t_next = mul_lo;
                OP_MIX_PREV:
                begin
                    x_next = item_reg.entropy_a ^ item_reg.time_now ^ t_reg ^ mul_lo;
                end
                OP_LOAD_C:    x_next = item_reg.entropy_c;
                OP_SES_FROM_X: ses_next = x_reg;
                OP_EMIT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_next            = 1'b1;
                        busy_next                 = 1'b0;
                        out_next.packet_id        = id_reg;
                        out_next.persist_write    = pw_reg;
                        out_next.persist_session  = pws_reg;
                        out_next.persist_sequence = pwq_reg;
                        out_next.persist_boots    = pwb_reg;
                        out_next.marker_write     = mark_reg;
                        out_next.cur_session      = ses_reg;
                        out_next.cur_sequence     = seq_reg;
                        out_next.cur_boots        = boots_reg;
                    end
                end
                default:
                begin
                end
            endcase

            case (uop.cond)
                COND_NEXT:        step_next = step_inc;
                COND_ALWAYS:      step_next = uop.target;
                COND_DISPATCH:    step_next = dispatch_step(item_reg.kind, started_reg);
                COND_IS_RAW:
                begin
                    step_next = (item_reg.kind == KIND_RAW) ? uop.target : step_inc;
                end
                COND_BELOW_LIMIT:
                begin
                    step_next = (seq_reg < SEQ_LIMIT) ? uop.target : step_inc;
                end
                COND_NO_MARKER:
                begin
                    step_next = item_reg.stored_marker_ok ? step_inc : uop.target;
                end
                COND_SEQ_OPEN:
                begin
                    step_next = (item_reg.kept_sequence < SEQ_LIMIT) ? uop.target
                                                                     : step_inc;
                end
                COND_X_NONZERO:
                begin
                    step_next = (x_reg != 32'd0) ? uop.target : step_inc;
                end
                COND_CALL:
                begin
                    link_next = step_inc;
                    step_next = uop.target;
                end
                COND_RETURN:      step_next = link_reg;
                default:          step_next = STEP_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_DISPATCH;
            link_reg      <= STEP_DISPATCH;
            started_reg   <= 1'b0;
            ses_reg       <= '0;
            seq_reg       <= '0;
            boots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            link_reg      <= link_next;
            started_reg   <= started_next;
            ses_reg       <= ses_next;
            seq_reg       <= seq_next;
            boots_reg     <= boots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        x_reg    <= x_next;
        t_reg    <= t_next;
        id_reg   <= id_next;
        pw_reg   <= pw_next;
        pws_reg  <= pws_next;
        pwq_reg  <= pwq_next;
        pwb_reg  <= pwb_next;
        mark_reg <= mark_next;
        out_reg  <= out_next;
    end

    assign in_gen      = busy_reg && (step_reg >= STEP_GEN) && (step_reg <= STEP_GEN_END);
    assign gen_link_ok = (link_reg == STEP_ROT_RET) || (link_reg == STEP_RESTORE_RET) ||
                         (link_reg == STEP_FRESH_RET);

    `PIDG_ASSERT_NEXT(a_started_sticky, started_reg, started_reg)
    `PIDG_ASSERT_NOW(a_done_emits, $fell(busy_reg), out_valid_reg)
    `PIDG_ASSERT_NOW(a_gen_link, in_gen, gen_link_ok)

endmodule

`default_nettype wire
